FILE: hdl/lrip_pkg.sv
// Shared widths, register indexes, side-band types and the CORDIC angle table.
package lrip_pkg;

  localparam int MAX_ROWS    = 128;
  localparam int MAX_COLUMNS = 4096;

  localparam int COORD_W = 20;               // point coordinate width
  localparam int SQ_W    = 40;               // sum of squares width
  localparam int RAD_W   = 60;               // radicand of the square root pipe
  localparam int ROOT_W  = 30;               // root width, one bit per stage
  localparam int REM_W   = ROOT_W + 3;       // root remainder width
  localparam int CW      = 34;               // CORDIC vector width
  localparam int ANG_W   = 24;               // angle width, 2^-20 rad
  localparam int CORDIC_STEPS = 20;
  localparam int DIV_W   = 24;               // dividend and quotient width
  localparam int DVS_W   = 21;               // divisor width
  localparam int DREM_W  = DVS_W + 1;        // divider remainder width

  localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(1647099);
  // 100 * sum >= 65536 holds exactly when sum >= 656
  localparam logic [SQ_W-1:0] MIN_SUM = SQ_W'(656);

  localparam logic [2:0] CFG_ROW_COUNT     = 3'd0;
  localparam logic [2:0] CFG_COLUMN_COUNT  = 3'd1;
  localparam logic [2:0] CFG_BOTTOM_OFFSET = 3'd2;
  localparam logic [2:0] CFG_ROW_STEP      = 3'd3;
  localparam logic [2:0] CFG_COLUMN_STEP   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      near_ok;
  } sq_side_t;

  typedef struct packed {
    logic [19:0] distance;
    logic        near_ok;
  } cd_side_t;

  typedef struct packed {
    logic [19:0] distance;
    logic        near_ok;
    logic        row_neg;
    logic        col_neg;
  } dv_side_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DIV_W-1:0]  quo;
    logic [DIV_W-1:0]  num;
  } div_lane_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ANG_W-1:0] atan_q20(input int step);
    case (step)
      0:  return ANG_W'(823550);
      1:  return ANG_W'(486170);
      2:  return ANG_W'(256879);
      3:  return ANG_W'(130396);
      4:  return ANG_W'(65451);
      5:  return ANG_W'(32757);
      6:  return ANG_W'(16383);
      7:  return ANG_W'(8192);
      8:  return ANG_W'(4096);
      9:  return ANG_W'(2048);
      10: return ANG_W'(1024);
      11: return ANG_W'(512);
      12: return ANG_W'(256);
      13: return ANG_W'(128);
      14: return ANG_W'(64);
      15: return ANG_W'(32);
      16: return ANG_W'(16);
      17: return ANG_W'(8);
      18: return ANG_W'(4);
      19: return ANG_W'(2);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hdl/lidar_range_image_projection.sv
// Top level: lidar point to spherical range image row, column, range and cell.
// One point enters per clock and its result leaves 79 register stages later: two
// stages square and sum the coordinates, two 30-stage square root pipes give the
// range and the horizontal distance, two 20-stage CORDIC pipes give elevation and
// azimuth, two 24-stage restoring dividers give the row and the column quotient,
// and three stages finish the column, the bounds test and the cell index. The
// whole pipe advances on one enable, so a stalled output beat freezes every stage
// and in_ready falls in the same cycle; nothing is dropped or repeated. Write the
// configuration registers only while no beat is in flight. There is no clearing
// pass after reset.
module lidar_range_image_projection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [19:0]  in_point_x,
  input  logic signed [19:0]  in_point_y,
  input  logic signed [19:0]  in_point_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_in_image,
  output logic [6:0]          out_row_index,
  output logic [11:0]         out_column_index,
  output logic [19:0]         out_distance,
  output logic [18:0]         out_cell_index
);

  localparam int SQRT_N = lrip_pkg::ROOT_W;
  localparam int CORD_N = lrip_pkg::CORDIC_STEPS;
  localparam int DIV_N  = lrip_pkg::DIV_W;

  // ---------------------------------------------------------------- config
  logic [7:0]         row_count_r;
  logic [12:0]        column_count_r;
  logic signed [17:0] bottom_offset_r;
  logic [19:0]        row_step_r;
  logic [19:0]        column_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= 8'd16;
      column_count_r  <= 13'd1800;
      bottom_offset_r <= 18'sd17270;
      row_step_r      <= 20'd34315;
      column_step_r   <= 20'd3660;
    end else if (cfg_we) begin
      case (cfg_index)
        lrip_pkg::CFG_ROW_COUNT:     row_count_r     <= cfg_data[7:0];
        lrip_pkg::CFG_COLUMN_COUNT:  column_count_r  <= cfg_data[12:0];
        lrip_pkg::CFG_BOTTOM_OFFSET: bottom_offset_r <= cfg_data[17:0];
        lrip_pkg::CFG_ROW_STEP:      row_step_r      <= cfg_data;
        lrip_pkg::CFG_COLUMN_STEP:   column_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the counts into range, treat a zero step as one
  logic [7:0]  rc;
  logic [12:0] cc;
  logic [19:0] rs;
  logic [19:0] cs;

  always_comb begin
    if (row_count_r == '0) begin
      rc = 8'd1;
    end else if (row_count_r > 8'(lrip_pkg::MAX_ROWS)) begin
      rc = 8'(lrip_pkg::MAX_ROWS);
    end else begin
      rc = row_count_r;
    end
    if (column_count_r == '0) begin
      cc = 13'd1;
    end else if (column_count_r > 13'(lrip_pkg::MAX_COLUMNS)) begin
      cc = 13'(lrip_pkg::MAX_COLUMNS);
    end else begin
      cc = column_count_r;
    end
    rs = (row_step_r == '0) ? 20'd1 : row_step_r;
    cs = (column_step_r == '0) ? 20'd1 : column_step_r;
  end

  // ---------------------------------------------------------------- flow
  // One enable for every stage: advance whenever the output register is empty
  // or its beat is being taken.
  logic pipe_en;
  logic p3_v_r;

  assign pipe_en  = !p3_v_r || out_ready;
  assign in_ready = pipe_en;

  // ---------------------------------------------------------------- squares
  logic                s1_v_r;
  logic signed [19:0]  s1_x_r, s1_y_r, s1_z_r;
  logic [38:0]         s1_xx_r, s1_yy_r, s1_zz_r;
  logic signed [39:0]  sq_x, sq_y, sq_z;

  assign sq_x = in_point_x * in_point_x;
  assign sq_y = in_point_y * in_point_y;
  assign sq_z = in_point_z * in_point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_x_r  <= in_point_x;
      s1_y_r  <= in_point_y;
      s1_z_r  <= in_point_z;
      s1_xx_r <= sq_x[38:0];
      s1_yy_r <= sq_y[38:0];
      s1_zz_r <= sq_z[38:0];
    end
  end

  // ---------------------------------------------------------------- sums
  logic                        s2_v_r;
  logic [lrip_pkg::SQ_W-1:0]   s2_hsq_r, s2_sum_r;
  lrip_pkg::sq_side_t          s2_side_r;
  logic [lrip_pkg::SQ_W-1:0]   hsq_c, sum_c;

  assign hsq_c = {1'b0, s1_xx_r} + {1'b0, s1_yy_r};
  assign sum_c = hsq_c + {1'b0, s1_zz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (pipe_en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_hsq_r          <= hsq_c;
      s2_sum_r          <= sum_c;
      s2_side_r.x       <= s1_x_r;
      s2_side_r.y       <= s1_y_r;
      s2_side_r.z       <= s1_z_r;
      s2_side_r.near_ok <= sum_c >= lrip_pkg::MIN_SUM;
    end
  end

  // ---------------------------------------------------------------- roots
  // The range root runs on sum * 2^20, so it carries ten fraction bits and
  // rounding to the nearest integer is an add of one half.
  logic [lrip_pkg::ROOT_W-1:0] dist_root, hyp_root;
  logic [SQRT_N-1:0]           vq_r;
  lrip_pkg::sq_side_t          sq_side_r [SQRT_N];

  lrip_sqrt u_sqrt_range (
    .clk    (clk),
    .en     (pipe_en),
    .rad_in ({s2_sum_r, 20'b0}),
    .root   (dist_root)
  );

  lrip_sqrt u_sqrt_hyp (
    .clk    (clk),
    .en     (pipe_en),
    .rad_in ({s2_hsq_r, 20'b0}),
    .root   (hyp_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= '0;
    end else if (pipe_en) begin
      vq_r <= {vq_r[SQRT_N-2:0], s2_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_side_r[0] <= s2_side_r;
      for (int k = 1; k < SQRT_N; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- angles
  lrip_pkg::sq_side_t                sq_last;
  logic [lrip_pkg::ROOT_W:0]         dist_rnd;
  logic [19:0]                       dist_c;
  logic signed [lrip_pkg::CW-1:0]    el_re, el_im, az_re, az_im;
  logic signed [lrip_pkg::ANG_W-1:0] elev, azim;
  logic [CORD_N-1:0]                 vc_r;
  lrip_pkg::cd_side_t                cd_side_r [CORD_N];

  assign sq_last  = sq_side_r[SQRT_N-1];
  assign dist_rnd = {1'b0, dist_root} + 31'd512;
  // saturate the range at the top of its field
  assign dist_c   = dist_rnd[30] ? 20'hFFFFF : dist_rnd[29:10];

  assign el_re = {4'b0, hyp_root};
  assign el_im = {{4{sq_last.z[19]}}, sq_last.z, 10'b0};
  assign az_re = {{4{sq_last.y[19]}}, sq_last.y, 10'b0};
  assign az_im = {{4{sq_last.x[19]}}, sq_last.x, 10'b0};

  lrip_cordic u_cordic_elev (
    .clk   (clk),
    .en    (pipe_en),
    .re_in (el_re),
    .im_in (el_im),
    .angle (elev)
  );

  lrip_cordic u_cordic_azim (
    .clk   (clk),
    .en    (pipe_en),
    .re_in (az_re),
    .im_in (az_im),
    .angle (azim)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (pipe_en) begin
      vc_r <= {vc_r[CORD_N-2:0], vq_r[SQRT_N-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cd_side_r[0].distance <= dist_c;
      cd_side_r[0].near_ok  <= sq_last.near_ok;
      for (int k = 1; k < CORD_N; k++) begin
        cd_side_r[k] <= cd_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  // Row: |elev + bottom_offset*16| / row_step, sign put back afterward.
  // Column: (2|az - pi/2| + column_step) / (2 column_step), i.e. a rounded
  // quotient, half away from zero.
  function automatic lrip_pkg::div_lane_t div_step(input lrip_pkg::div_lane_t src,
                                                   input logic [lrip_pkg::DVS_W-1:0] dvs);
    logic [lrip_pkg::DREM_W-1:0] sh;
    logic                        fits;
    lrip_pkg::div_lane_t         res;
    sh       = {src.rem[lrip_pkg::DREM_W-2:0], src.num[lrip_pkg::DIV_W-1]};
    fits     = sh >= {1'b0, dvs};
    res.rem  = fits ? sh - {1'b0, dvs} : sh;
    res.quo  = {src.quo[lrip_pkg::DIV_W-2:0], fits};
    res.num  = {src.num[lrip_pkg::DIV_W-2:0], 1'b0};
    return res;
  endfunction

  logic signed [24:0]              row_num, az_d;
  logic [24:0]                     row_abs, az_abs;
  logic [25:0]                     col_num;
  logic [lrip_pkg::DVS_W-1:0]      row_dvs, col_dvs;
  lrip_pkg::div_lane_t             row_lane_r [DIV_N];
  lrip_pkg::div_lane_t             col_lane_r [DIV_N];
  logic [DIV_N-1:0]                vd_r;
  lrip_pkg::dv_side_t              dv_side_r [DIV_N];

  assign row_num = {elev[23], elev} + {{3{bottom_offset_r[17]}}, bottom_offset_r, 4'b0};
  assign row_abs = row_num[24] ? -row_num : row_num;
  assign az_d    = {azim[23], azim} - {lrip_pkg::HALF_PI[23], lrip_pkg::HALF_PI};
  assign az_abs  = az_d[24] ? -az_d : az_d;
  assign col_num = {az_abs, 1'b0} + {6'b0, cs};
  assign row_dvs = {1'b0, rs};
  assign col_dvs = {cs, 1'b0};

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    lrip_pkg::div_lane_t row_src, col_src;

    if (k == 0) begin : g_first
      assign row_src = '{rem: '0, quo: '0, num: row_abs[lrip_pkg::DIV_W-1:0]};
      assign col_src = '{rem: '0, quo: '0, num: col_num[lrip_pkg::DIV_W-1:0]};
    end else begin : g_next
      assign row_src = row_lane_r[k-1];
      assign col_src = col_lane_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        row_lane_r[k] <= div_step(row_src, row_dvs);
        col_lane_r[k] <= div_step(col_src, col_dvs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (pipe_en) begin
      vd_r <= {vd_r[DIV_N-2:0], vc_r[CORD_N-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dv_side_r[0].distance <= cd_side_r[CORD_N-1].distance;
      dv_side_r[0].near_ok  <= cd_side_r[CORD_N-1].near_ok;
      dv_side_r[0].row_neg  <= row_num[24];
      dv_side_r[0].col_neg  <= az_d[24];
      for (int k = 1; k < DIV_N; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- finish
  lrip_pkg::dv_side_t  dv_last;
  logic signed [24:0]  row_s, colq_s;
  logic signed [26:0]  t2;
  logic signed [26:0]  col_h;

  assign dv_last = dv_side_r[DIV_N-1];
  assign row_s   = dv_last.row_neg ? -{1'b0, row_lane_r[DIV_N-1].quo}
                                   :  {1'b0, row_lane_r[DIV_N-1].quo};
  assign colq_s  = dv_last.col_neg ? -{1'b0, col_lane_r[DIV_N-1].quo}
                                   :  {1'b0, col_lane_r[DIV_N-1].quo};
  assign t2      = {14'b0, cc} - {colq_s[24], colq_s, 1'b0};
  // halve toward zero
  assign col_h   = (t2 + {26'b0, t2[26]}) >>> 1;

  logic               p1_v_r;
  logic signed [24:0] p1_row_r;
  logic signed [25:0] p1_col_r;
  logic [19:0]        p1_dist_r;
  logic               p1_near_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (pipe_en) begin
      p1_v_r <= vd_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_row_r  <= row_s;
      p1_col_r  <= col_h[25:0];
      p1_dist_r <= dv_last.distance;
      p1_near_r <= dv_last.near_ok;
    end
  end

  // wrap the column once, then test bounds and range
  logic signed [25:0] col_w;
  logic               ok_c;

  assign col_w = (p1_col_r >= $signed({13'b0, cc})) ? p1_col_r - $signed({13'b0, cc})
                                                    : p1_col_r;
  assign ok_c  = p1_near_r && !p1_row_r[24] && (p1_row_r[23:0] < {16'b0, rc}) &&
                 !col_w[25] && (col_w[24:0] < {12'b0, cc});

  logic        p2_v_r;
  logic        p2_ok_r;
  logic [6:0]  p2_row_r;
  logic [11:0] p2_col_r;
  logic [19:0] p2_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (pipe_en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p2_ok_r   <= ok_c;
      p2_row_r  <= ok_c ? p1_row_r[6:0] : 7'd0;
      p2_col_r  <= ok_c ? col_w[11:0] : 12'd0;
      p2_dist_r <= p1_dist_r;
    end
  end

  // cell index: column plus row times column count
  logic [19:0] cell_c;

  assign cell_c = {8'b0, p2_col_r} + p2_row_r * cc;

  logic        out_in_image_r;
  logic [6:0]  out_row_r;
  logic [11:0] out_col_r;
  logic [19:0] out_dist_r;
  logic [18:0] out_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (pipe_en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_in_image_r <= p2_ok_r;
      out_row_r      <= p2_row_r;
      out_col_r      <= p2_col_r;
      out_dist_r     <= p2_dist_r;
      out_cell_r     <= cell_c[18:0];
    end
  end

  assign out_valid        = p3_v_r;
  assign out_in_image     = out_in_image_r;
  assign out_row_index    = out_row_r;
  assign out_column_index = out_col_r;
  assign out_distance     = out_dist_r;
  assign out_cell_index   = out_cell_r;

  // ---------------------------------------------------------------- checks
  a_row_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_image |-> {1'b0, out_row_index} < rc)
    else $error("row outside configured rows");

  a_col_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_image |-> {1'b0, out_column_index} < cc)
    else $error("column outside configured columns");

  a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_image |->
      out_row_index == '0 && out_column_index == '0 && out_cell_index == '0)
    else $error("fields not cleared for a point outside the image");

  a_min_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_image |-> out_distance >= 20'd26)
    else $error("in-image point closer than the minimum range");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vq_r) && $stable(vc_r) && $stable(vd_r))
    else $error("pipeline moved while stalled");

endmodule

FILE: hdl/lrip_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module lrip_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [lrip_pkg::RAD_W-1:0]     rad_in,
  output logic [lrip_pkg::ROOT_W-1:0]    root
);

  logic [lrip_pkg::REM_W-1:0]  rem_r  [lrip_pkg::ROOT_W-1];
  logic [lrip_pkg::RAD_W-1:0]  rad_r  [lrip_pkg::ROOT_W-1];
  logic [lrip_pkg::ROOT_W-1:0] root_r [lrip_pkg::ROOT_W];

  for (genvar k = 0; k < lrip_pkg::ROOT_W; k++) begin : g_stage
    logic [lrip_pkg::RAD_W-1:0]  rad_src;
    logic [lrip_pkg::REM_W-1:0]  rem_src;
    logic [lrip_pkg::ROOT_W-1:0] root_src;
    logic [lrip_pkg::REM_W-1:0]  rem_sh;
    logic [lrip_pkg::REM_W-1:0]  trial;
    logic                        fits;

    if (k == 0) begin : g_first
      assign rad_src  = rad_in;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign rad_src  = rad_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_src[lrip_pkg::REM_W-3:0], rad_src[lrip_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_src, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_src[lrip_pkg::ROOT_W-2:0], fits};
      end
    end

    if (k < lrip_pkg::ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fits ? rem_sh - trial : rem_sh;
          rad_r[k] <= {rad_src[lrip_pkg::RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[lrip_pkg::ROOT_W-1];

endmodule

FILE: hdl/lrip_cordic.sv
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
module lrip_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [lrip_pkg::CW-1:0]      re_in,
  input  logic signed [lrip_pkg::CW-1:0]      im_in,
  output logic signed [lrip_pkg::ANG_W-1:0]   angle
);

  logic signed [lrip_pkg::CW-1:0]    re_r [lrip_pkg::CORDIC_STEPS];
  logic signed [lrip_pkg::CW-1:0]    im_r [lrip_pkg::CORDIC_STEPS];
  logic signed [lrip_pkg::ANG_W-1:0] z_r  [lrip_pkg::CORDIC_STEPS];

  for (genvar i = 0; i < lrip_pkg::CORDIC_STEPS; i++) begin : g_step
    logic signed [lrip_pkg::CW-1:0]    re_src;
    logic signed [lrip_pkg::CW-1:0]    im_src;
    logic signed [lrip_pkg::ANG_W-1:0] z_src;
    logic signed [lrip_pkg::CW-1:0]    re_nxt;
    logic signed [lrip_pkg::CW-1:0]    im_nxt;
    logic signed [lrip_pkg::ANG_W-1:0] z_nxt;

    if (i == 0) begin : g_first
      // fold the left half plane into the right one by a quarter turn
      always_comb begin
        if (re_in < 0) begin
          if (im_in >= 0) begin
            re_src = im_in;
            im_src = -re_in;
            z_src  = lrip_pkg::HALF_PI;
          end else begin
            re_src = -im_in;
            im_src = re_in;
            z_src  = -lrip_pkg::HALF_PI;
          end
        end else begin
          re_src = re_in;
          im_src = im_in;
          z_src  = '0;
        end
      end
    end else begin : g_next
      assign re_src = re_r[i-1];
      assign im_src = im_r[i-1];
      assign z_src  = z_r[i-1];
    end

    always_comb begin
      if (im_src > 0) begin
        re_nxt = re_src + (im_src >>> i);
        im_nxt = im_src - (re_src >>> i);
        z_nxt  = z_src + lrip_pkg::atan_q20(i);
      end else begin
        re_nxt = re_src - (im_src >>> i);
        im_nxt = im_src + (re_src >>> i);
        z_nxt  = z_src - lrip_pkg::atan_q20(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        re_r[i] <= re_nxt;
        im_r[i] <= im_nxt;
        z_r[i]  <= z_nxt;
      end
    end
  end

  assign angle = z_r[lrip_pkg::CORDIC_STEPS-1];

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the lidar range image projection pipe.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY     = 79;
  localparam int ITEM_COUNT  = 1850;
  localparam int CYCLE_LIMIT = 400000;

  // Register indexes that no register answers to.
  localparam logic [2:0] CFG_HOLE_LO = 3'd5;
  localparam logic [2:0] CFG_HOLE_HI = 3'd7;

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } point_t;

  typedef struct {
    logic        in_image;
    logic [6:0]  row_index;
    logic [11:0] column_index;
    logic [19:0] distance;
    logic [18:0] cell_index;
  } pixel_t;

  // One directed row: a point, and an optional typed-in expectation.
  typedef struct {
    point_t pt;
    bit     fixed;
    pixel_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [19:0] in_point_x, in_point_y, in_point_z;
  logic out_valid;
  logic out_ready;
  logic out_in_image;
  logic [6:0] out_row_index;
  logic [11:0] out_column_index;
  logic [19:0] out_distance;
  logic [18:0] out_cell_index;

  // Shadow copy of the configuration registers.
  logic [7:0]         row_count_q;
  logic [12:0]        column_count_q;
  logic signed [17:0] bottom_offset_q;
  logic [19:0]        row_step_q;
  logic [19:0]        column_step_q;

  pixel_t pixel_queue[$];
  int     error_count;
  int     cycle_count;

  lidar_range_image_projection dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_point_x, .in_point_y, .in_point_z,
    .out_valid, .out_ready, .out_in_image, .out_row_index,
    .out_column_index, .out_distance, .out_cell_index
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor shift that stays exact for negative values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // CORDIC vectoring: angle of (re, im) in 2^-20 rad.
  function automatic longint vector_angle(longint re, longint im);
    longint ang, t, nre, nim;
    ang = 0;
    if (re < 0) begin
      if (im >= 0) begin
        t = re; re = im; im = -t; ang = 1647099;
      end else begin
        t = re; re = -im; im = t; ang = -1647099;
      end
    end
    for (int i = 0; i < lrip_pkg::CORDIC_STEPS; i++) begin
      if (im > 0) begin
        nre = re + floor_shift(im, i);
        nim = im - floor_shift(re, i);
        ang = ang + longint'(lrip_pkg::atan_q20(i));
      end else begin
        nre = re - floor_shift(im, i);
        nim = im + floor_shift(re, i);
        ang = ang - longint'(lrip_pkg::atan_q20(i));
      end
      re = nre;
      im = nim;
    end
    return ang;
  endfunction

  function automatic longint trunc_div(longint a, longint b);
    return (a >= 0) ? a / b : -((-a) / b);
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t res;
    longint x, y, z, hsq, sum, r, rc, cc, rs, cs, elev, az, row, d, m, q, col;
    bit ok;
    x = p.x; y = p.y; z = p.z;
    hsq = x * x + y * y;
    sum = hsq + z * z;
    r = int_sqrt(sum);
    rc = row_count_q;
    cc = column_count_q;
    rs = (row_step_q == 0) ? 1 : row_step_q;
    cs = (column_step_q == 0) ? 1 : column_step_q;
    if (rc < 1) rc = 1;
    if (rc > lrip_pkg::MAX_ROWS) rc = lrip_pkg::MAX_ROWS;
    if (cc < 1) cc = 1;
    if (cc > lrip_pkg::MAX_COLUMNS) cc = lrip_pkg::MAX_COLUMNS;
    if (sum - r * r > r) r++;
    elev = vector_angle(int_sqrt(hsq << 20), z * 1024);
    row = trunc_div(elev + longint'(bottom_offset_q) * 16, rs);
    az = vector_angle(y * 1024, x * 1024);
    d = az - 1647099;
    m = (d < 0) ? -d : d;
    q = (2 * m + cs) / (2 * cs);
    if (d < 0) q = -q;
    col = trunc_div(cc - 2 * q, 2);
    if (col >= cc) col -= cc;
    ok = (100 * sum >= 65536) && row >= 0 && row < rc && col >= 0 && col < cc;
    res.in_image     = ok;
    res.row_index    = ok ? row[6:0] : '0;
    res.column_index = ok ? col[11:0] : '0;
    res.distance     = (r > 20'hFFFFF) ? 20'hFFFFF : r[19:0];
    res.cell_index   = ok ? 19'(col + row * cc) : '0;
    return res;
  endfunction

  // Write one register at the falling edge; mirror it in the shadow copy.
  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrip_pkg::CFG_ROW_COUNT:     row_count_q = val[7:0];
      lrip_pkg::CFG_COLUMN_COUNT:  column_count_q = val[12:0];
      lrip_pkg::CFG_BOTTOM_OFFSET: bottom_offset_q = val[17:0];
      lrip_pkg::CFG_ROW_STEP:      row_step_q = val;
      lrip_pkg::CFG_COLUMN_STEP:   column_step_q = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [7:0] rc, logic [12:0] cc, logic signed [17:0] bo,
                           logic [19:0] rs, logic [19:0] cs);
    write_reg(lrip_pkg::CFG_ROW_COUNT, 20'(rc));
    write_reg(lrip_pkg::CFG_COLUMN_COUNT, 20'(cc));
    write_reg(lrip_pkg::CFG_BOTTOM_OFFSET, 20'(unsigned'(bo)));
    write_reg(lrip_pkg::CFG_ROW_STEP, rs);
    write_reg(lrip_pkg::CFG_COLUMN_STEP, cs);
  endtask

  // Hold the point until the beat is taken; the gap comes first. Valid stays
  // high into the next beat when no gap is drawn.
  task automatic send_point(point_t p, bit fixed, pixel_t want);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= p.x;
    in_point_y <= p.y;
    in_point_z <= p.z;
    if (fixed)
      pixel_queue.insert(pixel_queue.size(), want);
    else
      pixel_queue.insert(pixel_queue.size(), project_point(p));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and drain everything in flight before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic point_t random_point();
    point_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // Typical scene: within a few tens of meters, mild elevation.
      p.x = 20'($signed($urandom_range(0, 40000)) - 20000);
      p.y = 20'($signed($urandom_range(0, 40000)) - 20000);
      p.z = 20'($signed($urandom_range(0, 6000)) - 3000);
    end else if (mode < 8) begin
      p.x = 20'($urandom);
      p.y = 20'($urandom);
      p.z = 20'($urandom);
    end else begin
      // Near the origin: around the minimum range.
      p.x = 20'($signed($urandom_range(0, 60)) - 30);
      p.y = 20'($signed($urandom_range(0, 60)) - 30);
      p.z = 20'($signed($urandom_range(0, 60)) - 30);
    end
    return p;
  endfunction

  // Receiver: wait a drawn number of cycles per beat, then check it against
  // the oldest expectation.
  initial begin
    pixel_t want;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pixel_queue.size() == 0) begin
        $error("unexpected beat: in_image %0d distance %0d", out_in_image, out_distance);
        error_count++;
      end else begin
        want = pixel_queue[0];
        pixel_queue.delete(0);
        if (out_in_image !== want.in_image) begin
          $error("in_image: expected %0d, actual %0d", want.in_image, out_in_image);
          error_count++;
        end
        if (out_row_index !== want.row_index) begin
          $error("row_index: expected %0d, actual %0d", want.row_index, out_row_index);
          error_count++;
        end
        if (out_column_index !== want.column_index) begin
          $error("column_index: expected %0d, actual %0d",
                 want.column_index, out_column_index);
          error_count++;
        end
        if (out_distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, out_distance);
          error_count++;
        end
        if (out_cell_index !== want.cell_index) begin
          $error("cell_index: expected %0d, actual %0d", want.cell_index, out_cell_index);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t dr;
    pixel_t none;
    error_count = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    row_count_q = 8'd16;
    column_count_q = 13'd1800;
    bottom_offset_q = 18'sd17270;
    row_step_q = 20'd34315;
    column_step_q = 20'd3660;
    none = '{default: '0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: origin and the minimum range edge read straight off the spec;
    // extremes, axes and the largest ranges go to the predictor.
    dr = '{pt: '{0, 0, 0}, fixed: 1, want: none};
    dir_rows.insert(dir_rows.size(), dr);
    dr = '{pt: '{25, 0, 0}, fixed: 1, want: '{0, 0, 0, 25, 0}};
    dir_rows.insert(dir_rows.size(), dr);
    dr.fixed = 0;
    dr.pt = '{26, 0, 0};                       dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, 26, 0};                       dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, 0, 26};                       dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{20'sh80000, 20'sh80000, 20'sh80000};
    dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{20'sd524287, 20'sd524287, 20'sd524287};
    dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{20'sd524287, 20'sh80000, 0};     dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, 2560, 0};                     dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, -2560, 0};                    dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{2560, 0, 0};                     dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{-2560, 0, 0};                    dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{-2560, -1, 0};                   dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{1000, 1000, 500};                dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{1000, 1000, -800};               dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, 0, 20'sh80000};               dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{0, 1000, 20'sd524287};           dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{20'sh80000, 0, 0};               dir_rows.insert(dir_rows.size(), dr);
    dr.pt = '{20'sd349525, 20'sd349525, 20'sd349525};
    dir_rows.insert(dir_rows.size(), dr);
    for (int i = 0; i < dir_rows.size(); i++)
      send_point(dir_rows[i].pt, dir_rows[i].fixed, dir_rows[i].want);

    // Random phases over several settings, extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: ;
        1: write_all(8'd128, 13'd4096, 18'sd102944, 20'd1, 20'd1);
        2: write_all(8'd1, 13'd1, -18'sd102944, 20'hFFFFF, 20'hFFFFF);
        3: write_all(8'd0, 13'd0, 18'sd0, 20'd0, 20'd0);
        4: write_all(8'd255, 13'h1FFF, 18'sh1FFFF, 20'd20000, 20'd5000);
        5: write_all(8'd64, 13'd1024, 18'sh20000, 20'd30000, 20'd6000);
        6: write_all(8'd32, 13'd3601, 18'sd20000, 20'd16000, 20'd1830);
        default: begin
          write_all(8'($urandom), 13'($urandom), 18'($urandom),
                    20'($urandom), 20'($urandom));
          write_reg(CFG_HOLE_LO, 20'($urandom));
          write_reg(CFG_HOLE_HI, 20'($urandom));
        end
      endcase
      repeat ((ITEM_COUNT - 19) / 8) begin
        send_point(random_point(), 0, none);
      end
    end

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
